// ----- hw/rtl/pp_pkg.sv -----
// ----------------------------------------------------------------------------
// pp_pkg
// Shared types and constants of the permutation parity block: field widths
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pp_pkg;

  // Width of one permutation entry as it arrives on the input channel.
  localparam int ENTRY_W = 4;

  // Width of the reported cycle count.
  localparam int CYCLE_W = 5;

  // Entries are four bits wide, so a walk can only ever land on the first
  // sixteen positions; those are the only positions that need a mark.
  localparam int VIS_MAX = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // store an accepted entry
    logic load_last;    // closing entry: latch length and start a walk
    logic skip;         // current start position already seen, move on
    logic start_cycle;  // open a new cycle at the current start position
    logic follow;       // step to the next position of the open cycle
    logic close;        // open cycle has ended, move the start position on
    logic publish;      // load the result register
  } pp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;    // every start position has been examined
    logic i_seen;       // current start position is already marked
    logic follow_ok;    // fetched position is in range and not yet marked
    logic out_busy;     // previous result still waits to be taken
  } pp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pp_if.sv -----
// ----------------------------------------------------------------------------
// pp_if
// Valid/ready channels of the permutation parity block: one for incoming
// permutation entries and one for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pp_in_if
  import pp_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_value;
  logic               last_entry;

  modport source (output valid, output entry_value, output last_entry, input ready);
  modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

interface pp_out_if
  import pp_pkg::*;
();

  logic               valid;
  logic               ready;
  logic               odd_parity;
  logic [CYCLE_W-1:0] cycle_total;
  logic               range_error;

  modport source (output valid, output odd_parity, output cycle_total,
                  output range_error, input ready);
  modport sink   (input valid, input odd_parity, input cycle_total,
                  input range_error, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/permutation_parity_core.sv -----
// ----------------------------------------------------------------------------
// permutation_parity_core
// Parity of a permutation by counting its cycles. Entries are loaded one
// beat at a time; the marked entry closes the load and starts the walk.
//
//   Channel   Role    Beat contents
//   entries   sink    entry_value (4 b), last_entry (1 b)
//   result    source  odd_parity (1 b), cycle_total (5 b), range_error (1 b)
//
// Loading accepts one entry per cycle. After the closing entry the walk scans
// each start position in turn and fetches the entries of each cycle through
// the single read port of the entry store. No entry is taken during the walk.
// A result waiting on the output does not block the next load; the walk only
// holds at its end until the result register is free. Reset clears the
// counters, visited marks and valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_parity_core
  import pp_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  pp_in_if.sink     entries,
  pp_out_if.source  result
);

  pp_cmd_t cmd;
  pp_sts_t sts;

  pp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (entries.valid),
    .in_last  (entries.last_entry),
    .in_ready (entries.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pp_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .entry_value (entries.entry_value),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .odd_parity  (result.odd_parity),
    .cycle_total (result.cycle_total),
    .range_error (result.range_error)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/pp_ctrl.sv -----
// ----------------------------------------------------------------------------
// pp_ctrl
// Controller of the permutation parity block. Sequences loading, the scan
// over start positions, the walk along each cycle and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pp_ctrl
  import pp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_last,
  output logic         in_ready,
  input  wire pp_sts_t sts,
  output pp_cmd_t      cmd
);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FOLLOW = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid;
        cmd.load_last = in_valid && in_last;
        if (in_valid && in_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          // Hold here until the result register is free.
          if (!sts.out_busy) begin
            cmd.publish = 1'b1;
            state_next  = S_LOAD;
          end
        end else if (sts.i_seen) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.start_cycle = 1'b1;
          state_next      = S_FOLLOW;
        end
      end
      S_FOLLOW: begin
        if (sts.follow_ok) begin
          cmd.follow = 1'b1;
        end else begin
          cmd.close  = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pp_datapath.sv -----
// ----------------------------------------------------------------------------
// pp_datapath
// Datapath of the permutation parity block: entry store, load counters,
// visited marks, walk pointers, cycle counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pp_datapath
  import pp_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pp_cmd_t            cmd,
  output pp_sts_t                 sts,
  input  wire logic [ENTRY_W-1:0] entry_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    odd_parity,
  output logic [CYCLE_W-1:0]      cycle_total,
  output logic                    range_error
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int VIS_N  = (MAX_LEN < VIS_MAX) ? MAX_LEN : VIS_MAX;
  localparam int VIS_IW = $clog2(VIS_N);
  localparam int CMP_W  = (LEN_W > ENTRY_W) ? LEN_W : ENTRY_W;

  logic [ENTRY_W-1:0] mem [MAX_LEN];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;

  logic [LEN_W-1:0]   cnt;
  logic [LEN_W-1:0]   cnt_next;
  logic [ENTRY_W-1:0] maxv;
  logic [ENTRY_W-1:0] maxv_next;
  logic               bad;
  logic               bad_next;
  logic               room;
  logic               range_bad;

  logic [LEN_W-1:0]   len;
  logic               err;
  logic [LEN_W-1:0]   i;
  logic [CYCLE_W-1:0] cycles;
  logic [VIS_N-1:0]   visited;
  logic               i_low;
  logic               j_fits;

  // Load bookkeeping: saturating length, largest stored value, overflow.
  always_comb begin
    room      = cnt < LEN_W'(MAX_LEN);
    cnt_next  = room ? cnt + LEN_W'(1) : cnt;
    maxv_next = (room && (entry_value > maxv)) ? entry_value : maxv;
    bad_next  = bad || !room;
    range_bad = CMP_W'(maxv_next) >= CMP_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      maxv <= '0;
      bad  <= 1'b0;
    end else if (cmd.load_last) begin
      cnt  <= '0;
      maxv <= '0;
      bad  <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= cnt_next;
      maxv <= maxv_next;
      bad  <= bad_next;
    end
  end

  // Length and error flag of the permutation under walk.
  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      len <= cnt_next;
      err <= bad_next || range_bad;
    end
  end

  // Entry store, one write port for loading and one registered read port
  // for the walk.
  assign rd_addr = cmd.follow ? ADDR_W'(rd_data) : i[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[cnt[ADDR_W-1:0]] <= entry_value;
    end
    if (cmd.start_cycle || cmd.follow) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Walk status. The fetched entry is the next position of the open cycle.
  always_comb begin
    i_low             = i < LEN_W'(VIS_N);
    j_fits            = CMP_W'(rd_data) < CMP_W'(len);
    sts.scan_done     = i == len;
    sts.i_seen        = i_low && visited[i[VIS_IW-1:0]];
    sts.follow_ok     = j_fits && !visited[rd_data[VIS_IW-1:0]];
    sts.out_busy      = out_valid;
  end

  // Visited marks, cleared when a walk starts.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_last) begin
      visited <= '0;
    end else begin
      if (cmd.start_cycle && i_low) begin
        visited[i[VIS_IW-1:0]] <= 1'b1;
      end
      if (cmd.follow) begin
        visited[rd_data[VIS_IW-1:0]] <= 1'b1;
      end
    end
  end

  // Start position and cycle counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_last) begin
      i      <= '0;
      cycles <= '0;
    end else begin
      if (cmd.skip || cmd.close) begin
        i <= i + LEN_W'(1);
      end
      if (cmd.start_cycle) begin
        cycles <= cycles + CYCLE_W'(1);
      end
    end
  end

  // Result register. Parity of length minus cycles is the XOR of their
  // lowest bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      odd_parity  <= len[0] ^ cycles[0];
      cycle_total <= cycles;
      range_error <= err;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pp_checker.sv -----
// ----------------------------------------------------------------------------
// pp_checker
// Port-level checks of the permutation parity block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pp_checker
  import pp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_last,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               odd_parity,
  input wire logic [CYCLE_W-1:0] cycle_total,
  input wire logic               range_error
);

  // A result stalled by the sink keeps its beat unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(odd_parity)
      && $stable(cycle_total) && $stable(range_error))
    else $error("result beat changed while stalled");

  // The walk starts right after the closing entry, so input stalls.
  a_walk_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("entry taken during the walk");

  // A new result only appears at the end of a walk, when input is stalled.
  a_result_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised outside a walk");

  // No result is shown straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind permutation_parity_core pp_checker u_pp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (entries.valid),
  .in_ready    (entries.ready),
  .in_last     (entries.last_entry),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .odd_parity  (result.odd_parity),
  .cycle_total (result.cycle_total),
  .range_error (result.range_error)
);

`default_nettype wire

// ----- tb/sv/permutation_parity_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_parity_core_tb
// Self-checking bench for the permutation parity block. A short table of
// hand-picked loads comes first, then a stream of random permutations, some
// corrupted, some with duplicates and some longer than the store. Every
// result beat is checked against a typed-in result or a cycle-counting
// predictor kept in the bench, under random stalls on both channels.
// ----------------------------------------------------------------------------

module permutation_parity_core_tb
  import pp_pkg::*;
();

  localparam int STORE_DEPTH  = 16;
  localparam int TOTAL_ITEMS  = 720;
  localparam int CALM_AFTER   = 600;
  localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic               odd_parity;
    logic [CYCLE_W-1:0] cycle_total;
    logic               range_error;
  } parity_result_t;

  // One row of the directed table; the result is typed in only when known_res
  // is set, otherwise the predictor supplies it.
  typedef struct {
    logic [ENTRY_W-1:0] value;
    bit                 last;
    bit                 known_res;
    parity_result_t     res;
  } load_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pp_in_if  entries_ch ();
  pp_out_if result_ch ();

  permutation_parity_core dut (
    .clk    (clk),
    .rst    (rst),
    .entries(entries_ch),
    .result (result_ch)
  );

  // Predictor state: the images loaded so far and the overflow flag.
  logic [ENTRY_W-1:0] perm_img [STORE_DEPTH];
  int                 img_count;
  bit                 overflowed;

  parity_result_t pending_results [$];
  load_row_t      load_table [$];
  int             mismatches  = 0;
  int             items_sent  = 0;
  int             cycle_count = 0;
  int             stall_left  = 0;
  bit             calm        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Take one accepted entry; on the closing entry walk the cycles and
  // return the result.
  function automatic bit tally_entry(input logic [ENTRY_W-1:0] value, input bit last,
                                     output parity_result_t res);
    logic [STORE_DEPTH-1:0] seen;
    int                     len;
    int                     cycles;
    int                     j;
    bit                     err;

    res = '0;
    if (img_count < STORE_DEPTH) begin
      perm_img[img_count] = value;
      img_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last) return 1'b0;

    len    = img_count;
    err    = overflowed;
    seen   = '0;
    cycles = 0;
    for (int i = 0; i < len; i++)
      if (int'(perm_img[i]) >= len) err = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (!seen[i]) begin
        cycles++;
        j = i;
        while (j < len && !seen[j]) begin
          seen[j] = 1'b1;
          j = int'(perm_img[j]);
        end
      end
    end

    res.odd_parity  = 1'((len - cycles) & 1);
    res.cycle_total = CYCLE_W'(cycles);
    res.range_error = err;
    img_count  = 0;
    overflowed = 1'b0;
    return 1'b1;
  endfunction

  // Drive one entry beat, entered and left at a falling edge.
  task automatic push_entry(input logic [ENTRY_W-1:0] value, input bit last,
                            input bit known_res, input parity_result_t typed);
    parity_result_t predicted;
    bit             produced;

    if (!calm && $urandom_range(0, 3) == 0) begin
      entries_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    entries_ch.valid       <= 1'b1;
    entries_ch.entry_value <= value;
    entries_ch.last_entry  <= last;
    do @(posedge clk); while (!entries_ch.ready);
    produced = tally_entry(value, last, predicted);
    if (produced) pending_results.push_back(known_res ? typed : predicted);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  // Send one random load: mostly true permutations, the rest corrupted,
  // random or too long for the store.
  task automatic send_random_load();
    logic [ENTRY_W-1:0] img [24];
    logic [ENTRY_W-1:0] tmp;
    int                 kind;
    int                 len;
    int                 n;
    int                 k;

    kind = $urandom_range(0, 99);
    if (kind >= 95) len = STORE_DEPTH;
    else if (kind >= 90) len = $urandom_range(STORE_DEPTH + 1, 24);
    else len = $urandom_range(1, STORE_DEPTH);
    n = (len > STORE_DEPTH) ? STORE_DEPTH : len;

    for (int i = 0; i < n; i++) img[i] = ENTRY_W'(i);
    for (int i = n - 1; i > 0; i--) begin
      k      = $urandom_range(0, i);
      tmp    = img[i];
      img[i] = img[k];
      img[k] = tmp;
    end

    if (kind >= 70 && kind < 80) begin
      img[$urandom_range(0, n - 1)] = ENTRY_W'($urandom_range(0, 15));
    end else if (kind >= 80 && kind < 95) begin
      for (int i = 0; i < len; i++) img[i] = ENTRY_W'($urandom_range(0, 15));
    end

    for (int i = 0; i < len; i++) push_entry(img[i], i == len - 1, 1'b0, '0);
  endtask

  // Result side: random stall bursts until the closing stretch.
  always @(negedge clk) begin
    if (calm) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    parity_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (cycle_total %0d)",
                                  result_ch.cycle_total));
      end else begin
        want = pending_results.pop_front();
        if (result_ch.odd_parity !== want.odd_parity)
          report_mismatch($sformatf("odd_parity got %0b, expected %0b",
                                    result_ch.odd_parity, want.odd_parity));
        if (result_ch.cycle_total !== want.cycle_total)
          report_mismatch($sformatf("cycle_total got %0d, expected %0d",
                                    result_ch.cycle_total, want.cycle_total));
        if (result_ch.range_error !== want.range_error)
          report_mismatch($sformatf("range_error got %0b, expected %0b",
                                    result_ch.range_error, want.range_error));
      end
    end
  end

  initial begin
    entries_ch.valid       = 1'b0;
    entries_ch.entry_value = '0;
    entries_ch.last_entry  = 1'b0;
    result_ch.ready        = 1'b0;
    img_count  = 0;
    overflowed = 1'b0;
    foreach (perm_img[i]) perm_img[i] = '0;

    // Directed loads: a fixed point, an out-of-range single entry, a swap,
    // a duplicate image, and an overflowing load of the top value.
    load_table.push_back('{4'd0,  1'b1, 1'b1, '{1'b0, 5'd1, 1'b0}});
    load_table.push_back('{4'd15, 1'b1, 1'b1, '{1'b0, 5'd1, 1'b1}});
    load_table.push_back('{4'd1,  1'b0, 1'b0, '0});
    load_table.push_back('{4'd0,  1'b1, 1'b1, '{1'b1, 5'd1, 1'b0}});
    load_table.push_back('{4'd0,  1'b0, 1'b0, '0});
    load_table.push_back('{4'd0,  1'b1, 1'b0, '0});
    for (int i = 0; i < STORE_DEPTH; i++) load_table.push_back('{4'd15, 1'b0, 1'b0, '0});
    load_table.push_back('{4'd15, 1'b1, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (load_table[r])
      push_entry(load_table[r].value, load_table[r].last, load_table[r].known_res,
                 load_table[r].res);

    while (items_sent < TOTAL_ITEMS) send_random_load();
    entries_ch.valid <= 1'b0;

    // Wait for the last results, then watch for stray beats.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pp_pkg.sv
hw/rtl/pp_if.sv
hw/rtl/pp_ctrl.sv
hw/rtl/pp_datapath.sv
hw/rtl/permutation_parity_core.sv
hw/rtl/pp_checker.sv
tb/sv/permutation_parity_core_tb.sv
